// ===== rtl/b32c_pkg.sv =====
`default_nettype none

package b32c_pkg;

    // frame length and crc defaults
    localparam int         MAX_FRAME_BYTES_DEF = 8;
    localparam logic [3:0] FRAME_BYTES_RESET   = 4'd8;
    localparam logic [7:0] CRC_SEED_RESET      = 8'hA5;
    localparam logic [7:0] CRC_POLY            = 8'h07;
    localparam logic [3:0] FRAME_BYTES_MIN     = 4'd2;

    // command of an input transaction
    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_END  = 1'b1
    } t_cmd;

    // kind of a result transaction
    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    // final status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_CHAR  = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_TOO_SHORT = 3'd3,
        ST_CRC_BAD   = 3'd4
    } t_status;

    // configuration register indexes
    typedef enum logic {
        REG_FRAME_BYTES = 1'b0,
        REG_CRC_SEED    = 1'b1
    } t_reg_idx;

    // registered input item
    typedef struct packed {
        t_cmd       command;
        logic [7:0] char_code;
    } t_item;

    // live configuration
    typedef struct packed {
        logic [3:0] frame_bytes;
        logic [7:0] crc_seed;
    } t_cfg;

    // alphabet lookup result
    typedef struct packed {
        logic       ok;
        logic [4:0] value;
    } t_sym;

    // fold lower case, then map through the 32-symbol alphabet
    function automatic t_sym symbol_lookup(input logic [7:0] ch);
        logic [7:0] c;
        t_sym       s;
        c = ch;
        if (ch >= "a" && ch <= "z") begin
            c = ch - 8'h20;
        end
        s.ok = 1'b1;
        s.value = 5'd0;
        case (c)
            "2": s.value = 5'd0;
            "3": s.value = 5'd1;
            "4": s.value = 5'd2;
            "5": s.value = 5'd3;
            "6": s.value = 5'd4;
            "7": s.value = 5'd5;
            "8": s.value = 5'd6;
            "9": s.value = 5'd7;
            "A": s.value = 5'd8;
            "B": s.value = 5'd9;
            "C": s.value = 5'd10;
            "D": s.value = 5'd11;
            "E": s.value = 5'd12;
            "F": s.value = 5'd13;
            "G": s.value = 5'd14;
            "H": s.value = 5'd15;
            "J": s.value = 5'd16;
            "K": s.value = 5'd17;
            "L": s.value = 5'd18;
            "M": s.value = 5'd19;
            "N": s.value = 5'd20;
            "P": s.value = 5'd21;
            "Q": s.value = 5'd22;
            "R": s.value = 5'd23;
            "S": s.value = 5'd24;
            "T": s.value = 5'd25;
            "U": s.value = 5'd26;
            "V": s.value = 5'd27;
            "W": s.value = 5'd28;
            "X": s.value = 5'd29;
            "Y": s.value = 5'd30;
            "Z": s.value = 5'd31;
            default: s.ok = 1'b0;
        endcase
        return s;
    endfunction

    // crc-8 over one byte, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/b32c_if.sv =====
`default_nettype none

// character / end command channel
interface b32c_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_code;

    modport source (output valid, output command, output char_code, input ready);
    modport sink   (input valid, input command, input char_code, output ready);
endinterface

// decoded byte / status channel
interface b32c_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] data_byte;
    logic [2:0] byte_index;
    logic [2:0] status;
    logic [3:0] byte_count;

    modport source (output valid, output result_kind, output data_byte, output byte_index,
                    output status, output byte_count, input ready);
    modport sink   (input valid, input result_kind, input data_byte, input byte_index,
                    input status, input byte_count, output ready);
endinterface

// register write channel
interface b32c_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/base32_crc8_code_decoder.sv =====
`default_nettype none

// channel  dir  transaction
// i_in     in   one character (command 0) or end of code (command 1)
// o_out    out  decoded byte with its index, or final status with byte count
// i_cfg    in   register write: 0 frame_bytes, 1 crc_seed
//
// one item per cycle while o_out.ready holds; an input transaction reaches the
// result through the input register, then decode, crc and the result register
// i_rst_n is synchronous; no clearing pass, the block is ready right after reset
// i_in.ready drops only when both the input and the result register hold
// items and o_out.ready is low; i_cfg.ready is always high

module base32_crc8_code_decoder #(
    parameter int MAX_FRAME_BYTES = b32c_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    b32c_in_if.sink     i_in,
    b32c_out_if.source  o_out,
    b32c_cfg_if.sink    i_cfg
);

    b32c_pkg::t_cfg  cfg;
    b32c_pkg::t_item item;
    logic            item_valid;
    logic            take;

    // configuration registers
    b32c_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // input register
    b32c_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    // decode, crc and result register
    b32c_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (item_valid),
        .i_item  (item),
        .i_cfg   (cfg),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/b32c_cfg_regs.sv =====
`default_nettype none

module b32c_cfg_regs (
    input  wire           i_clk,
    input  wire           i_rst_n,
    b32c_cfg_if.sink      i_cfg,
    output b32c_pkg::t_cfg o_cfg
);

    logic [3:0] r_frame_bytes;
    logic [7:0] r_crc_seed;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= b32c_pkg::FRAME_BYTES_RESET;
            r_crc_seed    <= b32c_pkg::CRC_SEED_RESET;
        end else if (i_cfg.valid) begin
            unique case (b32c_pkg::t_reg_idx'(i_cfg.index))
                b32c_pkg::REG_FRAME_BYTES: r_frame_bytes <= i_cfg.data[3:0];
                b32c_pkg::REG_CRC_SEED:    r_crc_seed    <= i_cfg.data;
                default:                   r_crc_seed    <= r_crc_seed;
            endcase
        end
    end

    assign o_cfg.frame_bytes = r_frame_bytes;
    assign o_cfg.crc_seed    = r_crc_seed;

endmodule

`default_nettype wire

// ===== rtl/b32c_in_stage.sv =====
`default_nettype none

module b32c_in_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    b32c_in_if.sink          i_in,
    input  wire              i_take,
    output logic             o_valid,
    output b32c_pkg::t_item  o_item
);

    logic            r_valid;
    b32c_pkg::t_item r_item;
    logic            accept;

    // room when empty or when the held item moves on this cycle
    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.command   <= b32c_pkg::t_cmd'(i_in.command);
            r_item.char_code <= i_in.char_code;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/b32c_core.sv =====
`default_nettype none

module b32c_core #(
    parameter int MAX_FRAME_BYTES = b32c_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  b32c_pkg::t_item  i_item,
    input  b32c_pkg::t_cfg   i_cfg,
    output logic             o_take,
    b32c_out_if.source       o_out
);

    localparam int DW = $clog2(MAX_FRAME_BYTES + 1);

    // per-code state
    logic [11:0]       r_acc,   n_acc;
    logic [2:0]        r_pend,  n_pend;
    logic [DW-1:0]     r_done,  n_done;
    logic [7:0]        r_crc,   n_crc;
    logic              r_match, n_match;
    b32c_pkg::t_status r_err,   n_err;

    // result register
    logic              r_out_valid, n_out_valid;
    b32c_pkg::t_kind   r_kind,   n_kind;
    logic [7:0]        r_data,   n_data;
    logic [2:0]        r_index,  n_index;
    b32c_pkg::t_status r_status, n_status;
    logic [3:0]        r_count,  n_count;

    logic [DW-1:0]     flen;
    b32c_pkg::t_sym    sym;
    logic              skip;
    logic [11:0]       acc_shift;
    logic [3:0]        pend_sum;
    logic [2:0]        pend_left;
    logic [7:0]        byte_val;
    logic [DW:0]       done_inc;
    logic [7:0]        crc_base;
    logic [7:0]        crc_next;
    b32c_pkg::t_status end_status;

    // advance when the result register is free or drains this cycle
    assign o_take = i_valid && (!r_out_valid || o_out.ready);

    // clamp frame length to the supported range
    always_comb begin
        if (i_cfg.frame_bytes < b32c_pkg::FRAME_BYTES_MIN) begin
            flen = DW'(b32c_pkg::FRAME_BYTES_MIN);
        end else if (int'(i_cfg.frame_bytes) > MAX_FRAME_BYTES) begin
            flen = DW'(MAX_FRAME_BYTES);
        end else begin
            flen = DW'(i_cfg.frame_bytes);
        end
    end

    // character decode and byte assembly
    assign sym  = b32c_pkg::symbol_lookup(i_item.char_code);
    assign skip = (i_item.char_code == "-") || (i_item.char_code == " ") ||
                  (i_item.char_code == 8'h09);
    assign acc_shift = {r_acc[6:0], sym.value};
    assign pend_sum  = {1'b0, r_pend} + 4'd5;
    assign pend_left = 3'(pend_sum - 4'd8);
    assign byte_val  = 8'(acc_shift >> pend_left);
    assign done_inc  = {1'b0, r_done} + (DW+1)'(1);

    // crc restarts from the live seed at the first byte
    assign crc_base = (r_done == '0) ? i_cfg.crc_seed : r_crc;
    assign crc_next = b32c_pkg::crc8_byte(crc_base, byte_val);

    // end-of-code status by priority
    always_comb begin
        if (r_err != b32c_pkg::ST_OK) begin
            end_status = r_err;
        end else if (r_done < flen) begin
            end_status = b32c_pkg::ST_TOO_SHORT;
        end else if (!r_match) begin
            end_status = b32c_pkg::ST_CRC_BAD;
        end else begin
            end_status = b32c_pkg::ST_OK;
        end
    end

    // next state
    always_comb begin
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_done      = r_done;
        n_crc       = r_crc;
        n_match     = r_match;
        n_err       = r_err;
        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_data      = r_data;
        n_index     = r_index;
        n_status    = r_status;
        n_count     = r_count;
        if (o_take) begin
            if (i_item.command == b32c_pkg::CMD_END) begin
                n_out_valid = 1'b1;
                n_kind      = b32c_pkg::KIND_STATUS;
                n_data      = 8'd0;
                n_index     = 3'd0;
                n_status    = end_status;
                n_count     = 4'(r_done);
                n_acc       = 12'd0;
                n_pend      = 3'd0;
                n_done      = '0;
                n_crc       = i_cfg.crc_seed;
                n_match     = 1'b0;
                n_err       = b32c_pkg::ST_OK;
            end else if (skip || r_err != b32c_pkg::ST_OK) begin
                n_acc = r_acc;
            end else if (!sym.ok) begin
                n_err = b32c_pkg::ST_BAD_CHAR;
            end else begin
                n_acc = acc_shift;
                if (pend_sum < 4'd8) begin
                    n_pend = pend_sum[2:0];
                end else begin
                    n_pend = pend_left;
                    if (r_done >= flen) begin
                        n_err = b32c_pkg::ST_TOO_LONG;
                    end else begin
                        // last byte of the frame is the check byte
                        if (done_inc < {1'b0, flen}) begin
                            n_crc = crc_next;
                        end else begin
                            n_match = (byte_val == r_crc);
                        end
                        n_out_valid = 1'b1;
                        n_kind      = b32c_pkg::KIND_DATA;
                        n_data      = byte_val;
                        n_index     = 3'(r_done);
                        n_status    = b32c_pkg::ST_OK;
                        n_count     = 4'd0;
                        n_done      = done_inc[DW-1:0];
                    end
                end
            end
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 12'd0;
            r_pend      <= 3'd0;
            r_done      <= '0;
            r_crc       <= b32c_pkg::CRC_SEED_RESET;
            r_match     <= 1'b0;
            r_err       <= b32c_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_pend      <= n_pend;
            r_done      <= n_done;
            r_crc       <= n_crc;
            r_match     <= n_match;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_data   <= n_data;
        r_index  <= n_index;
        r_status <= n_status;
        r_count  <= n_count;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_kind;
    assign o_out.data_byte   = r_data;
    assign o_out.byte_index  = r_index;
    assign o_out.status      = r_status;
    assign o_out.byte_count  = r_count;

    // an end command leaves the code state cleared
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.command == b32c_pkg::CMD_END) |=>
            (r_done == '0 && r_pend == 3'd0 && r_err == b32c_pkg::ST_OK))
        else $error("code state not cleared after end command");

    // no result after a character once an error is latched
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.command == b32c_pkg::CMD_CHAR && r_err != b32c_pkg::ST_OK)
            |=> !r_out_valid)
        else $error("result produced while error latched");

    // byte count never passes the largest frame
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_done) <= MAX_FRAME_BYTES)
        else $error("byte count beyond frame limit");

    // only character and too-long errors are ever latched
    a_err_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err == b32c_pkg::ST_OK || r_err == b32c_pkg::ST_BAD_CHAR ||
         r_err == b32c_pkg::ST_TOO_LONG))
        else $error("unexpected latched error code");

endmodule

`default_nettype wire
